### sv/stq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Command codes, input and result words, the control word that the top level
// broadcasts to the cell row, and the configuration reset value.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int SLOT_COUNT_DEFAULT = 16;
    localparam int TIME_BITS_DEFAULT  = 32;

    localparam logic [30:0] MAX_TIMEOUT_RESET = 31'd60000;

    typedef enum logic [1:0] {
        ACT_SCHEDULE = 2'd0,
        ACT_CANCEL   = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_SERVICE  = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [3:0]         slot;
        logic signed [31:0] delay_ms;
        logic               wants_cancel_notice;
    } t_stq_in;

    typedef struct packed {
        logic        status;
        logic        fired;
        logic [3:0]  fired_slot;
        logic        cancel_notice;
        logic [30:0] next_timeout_ms;
        logic [4:0]  pending_count;
    } t_stq_out;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic cap;       // capture compare and match flags
        logic match_en;  // slot matching is meaningful for this command
        logic ins;       // insert the new timer at its ordered place
        logic rm;        // remove the marked entry and close the gap
    } t_cell_ctrl;

endpackage

### sv/sorted_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue: timer slots kept in fire-time order in a row of cells
// Schedule, cancel, tick and service commands against a wrapping clock.
// ----------------------------------------------------------------------------
// A command taken by start passes through the compare, list update and
// timeout calculation states, with busy high throughout, so a new command is
// not taken before the last one is through; start may be taken again
// in the cycle that shows the result. The receiver cannot stall.
// Reset (synchronous, active low) empties the list, zeroes the clock and
// sets the maximum timeout to 60000 ms.
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
    parameter int TIME_BITS  = TIME_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_stq_in     i_item,
    output logic        o_strobe,
    output t_stq_out    o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int CW     = (TIME_BITS > 31) ? TIME_BITS : 31;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_RES  = 4'b1000
    } t_state;

    t_state               r_state;
    t_stq_in              r_cmd;
    logic                 r_in_range;
    logic [TIME_BITS-1:0] r_new_time;
    logic [TIME_BITS-1:0] r_now;
    logic [CNT_W-1:0]     r_count;
    logic                 r_due;
    logic                 r_status;
    logic                 r_fired;
    logic [3:0]           r_fired_slot;
    logic                 r_notice;
    logic [30:0]          r_max;
    logic                 r_strobe;
    t_stq_out             r_result;

    t_cell_ctrl           ctrl;
    logic [SLOT_W-1:0]    cmd_slot;
    logic [31:0]          delay_clamped;
    logic                 is_sched;
    logic                 is_cancel;
    logic                 is_service;
    logic                 any_hit;
    logic                 any_hit_notice;
    logic [TIME_BITS-1:0] head_rem;
    logic [CW-1:0]        rem_w;
    logic [30:0]          next_timeout;

    // Neighbor buses: entry k+1 belongs to cell k, the two ends are empty.
    logic                 x_valid  [0:SLOT_COUNT+1];
    logic [SLOT_W-1:0]    x_slot   [0:SLOT_COUNT+1];
    logic [TIME_BITS-1:0] x_time   [0:SLOT_COUNT+1];
    logic                 x_notice [0:SLOT_COUNT+1];
    logic [SLOT_COUNT-1:0] hit_vec;
    logic [SLOT_COUNT-1:0] hit_notice_vec;
    logic                 chain    [0:SLOT_COUNT];

    assign x_valid[0]             = 1'b0;
    assign x_slot[0]              = '0;
    assign x_time[0]              = '0;
    assign x_notice[0]            = 1'b0;
    assign x_valid[SLOT_COUNT+1]  = 1'b0;
    assign x_slot[SLOT_COUNT+1]   = '0;
    assign x_time[SLOT_COUNT+1]   = '0;
    assign x_notice[SLOT_COUNT+1] = 1'b0;

    assign cmd_slot      = SLOT_W'(r_cmd.slot);
    assign is_sched      = (r_cmd.action == ACT_SCHEDULE);
    assign is_cancel     = (r_cmd.action == ACT_CANCEL);
    assign is_service    = (r_cmd.action == ACT_SERVICE);
    assign delay_clamped = i_item.delay_ms[31] ? 32'd0 : $unsigned(i_item.delay_ms);
    assign any_hit        = |hit_vec;
    assign any_hit_notice = |hit_notice_vec;

    always_comb begin
        ctrl.cap      = (r_state == S_CMP);
        ctrl.match_en = r_in_range && (is_sched || is_cancel);
        ctrl.ins      = (r_state == S_UPD) && is_sched && r_in_range && !any_hit;
        ctrl.rm       = (r_state == S_UPD)
                        && ((is_cancel && any_hit) || (is_service && r_due));
    end

    // A service removal enters the ripple at the head.
    assign chain[0] = ctrl.rm && is_service;

    genvar k;
    generate
        for (k = 0; k < SLOT_COUNT; k++) begin : g_cell
            stq_cell #(
                .SLOT_W    (SLOT_W),
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_new_slot   (cmd_slot),
                .i_new_time   (r_new_time),
                .i_new_notice (r_cmd.wants_cancel_notice),
                .i_prev_valid (x_valid[k]),
                .i_prev_slot  (x_slot[k]),
                .i_prev_time  (x_time[k]),
                .i_prev_notice(x_notice[k]),
                .i_next_valid (x_valid[k+2]),
                .i_next_slot  (x_slot[k+2]),
                .i_next_time  (x_time[k+2]),
                .i_next_notice(x_notice[k+2]),
                .i_found      (chain[k]),
                .o_found      (chain[k+1]),
                .o_valid      (x_valid[k+1]),
                .o_slot       (x_slot[k+1]),
                .o_time       (x_time[k+1]),
                .o_notice     (x_notice[k+1]),
                .o_hit        (hit_vec[k]),
                .o_hit_notice (hit_notice_vec[k])
            );
        end
    endgenerate

    // Time left on the head timer, judged by signed wrapping difference.
    assign head_rem = x_time[1] - r_now;
    assign rem_w    = CW'(head_rem);

    always_comb begin
        if (!x_valid[1]) begin
            next_timeout = r_max;
        end else if (head_rem[TIME_BITS-1]) begin
            next_timeout = '0;
        end else if (rem_w < CW'(r_max)) begin
            next_timeout = 31'(rem_w);
        end else begin
            next_timeout = r_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_now    <= '0;
            r_count  <= '0;
            r_max    <= MAX_TIMEOUT_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd      <= i_item;
                        r_in_range <= (int'(i_item.slot) < SLOT_COUNT);
                        r_new_time <= r_now + TIME_BITS'(delay_clamped);
                        r_state    <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_due   <= x_valid[1] && (head_rem[TIME_BITS-1] || head_rem == '0);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_status     <= is_sched && r_in_range && any_hit;
                    r_notice     <= is_cancel && any_hit_notice;
                    r_fired      <= ctrl.rm && is_service;
                    r_fired_slot <= (ctrl.rm && is_service) ? 4'(x_slot[1]) : 4'd0;
                    if (ctrl.ins && chain[SLOT_COUNT]) begin
                        r_count <= r_count + 1'b1;
                    end else if (ctrl.rm && chain[SLOT_COUNT]) begin
                        r_count <= r_count - 1'b1;
                    end
                    if (r_cmd.action == ACT_TICK) begin
                        r_now <= r_now + 1'b1;
                    end
                    r_state <= S_RES;
                end
                S_RES: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RES) begin
            r_result.status          <= r_status;
            r_result.fired           <= r_fired;
            r_result.fired_slot      <= r_fired_slot;
            r_result.cancel_notice   <= r_notice;
            r_result.next_timeout_ms <= next_timeout;
            r_result.pending_count   <= 5'(r_count);
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

endmodule

### sv/stq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_cell: one position of the ordered timer list
// Holds one entry (slot, fire time, notice flag) and shifts toward its
// neighbors on insert and remove, driven by a ripple of position flags.
// ----------------------------------------------------------------------------
module stq_cell
    import stq_pkg::*;
#(
    parameter int SLOT_W    = 4,
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctrl           i_ctrl,
    input  logic [SLOT_W-1:0]    i_new_slot,
    input  logic [TIME_BITS-1:0] i_new_time,
    input  logic                 i_new_notice,
    input  logic                 i_prev_valid,
    input  logic [SLOT_W-1:0]    i_prev_slot,
    input  logic [TIME_BITS-1:0] i_prev_time,
    input  logic                 i_prev_notice,
    input  logic                 i_next_valid,
    input  logic [SLOT_W-1:0]    i_next_slot,
    input  logic [TIME_BITS-1:0] i_next_time,
    input  logic                 i_next_notice,
    input  logic                 i_found,
    output logic                 o_found,
    output logic                 o_valid,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [TIME_BITS-1:0] o_time,
    output logic                 o_notice,
    output logic                 o_hit,
    output logic                 o_hit_notice
);

    logic                 r_valid;
    logic [SLOT_W-1:0]    r_slot;
    logic [TIME_BITS-1:0] r_time;
    logic                 r_notice;
    logic                 r_cand;
    logic                 r_hit;
    logic [TIME_BITS-1:0] new_minus_mine;

    // The new timer goes ahead of this entry when it fires strictly earlier.
    assign new_minus_mine = i_new_time - r_time;

    always_comb begin
        o_found = i_found;
        if (i_ctrl.ins) begin
            o_found = i_found | r_cand;
        end else if (i_ctrl.rm) begin
            o_found = i_found | r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cand  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_ctrl.cap) begin
                r_cand <= !r_valid || new_minus_mine[TIME_BITS-1];
                r_hit  <= i_ctrl.match_en && r_valid && (r_slot == i_new_slot);
            end
            if (i_ctrl.ins) begin
                if (i_found) begin
                    r_valid  <= i_prev_valid;
                    r_slot   <= i_prev_slot;
                    r_time   <= i_prev_time;
                    r_notice <= i_prev_notice;
                end else if (r_cand) begin
                    r_valid  <= 1'b1;
                    r_slot   <= i_new_slot;
                    r_time   <= i_new_time;
                    r_notice <= i_new_notice;
                end
            end else if (i_ctrl.rm && o_found) begin
                r_valid  <= i_next_valid;
                r_slot   <= i_next_slot;
                r_time   <= i_next_time;
                r_notice <= i_next_notice;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_slot       = r_slot;
    assign o_time       = r_time;
    assign o_notice     = r_notice;
    assign o_hit        = r_hit;
    assign o_hit_notice = r_hit & r_notice;

endmodule

### sv/stq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_checker: port-level checks of the sorted timer queue
// Watches the command and result ports and flags timing or result slips.
// ----------------------------------------------------------------------------
module stq_checker
    import stq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input t_stq_in     i_item,
    input logic        o_strobe,
    input t_stq_out    o_result,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [30:0] i_cfg_data
);

    // Every accepted word gets its result strobe after the compare, update and result states.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("result strobe missing four cycles after an accepted word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted word");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while a command is still in progress");

    // A fire is neither a rejected schedule nor a cancel.
    a_fire_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.fired) |-> (!o_result.status && !o_result.cancel_notice))
        else $error("fire reported together with status or cancel notice");

    a_fired_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.fired) |-> (o_result.fired_slot == 4'd0))
        else $error("fired slot nonzero without a fire");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);
